// ----- hw/rtl/q2rm_pkg.sv -----
`timescale 1ns / 1ps

package q2rm_pkg;

  // input word: one quaternion, signed Q4.12 components
  typedef struct packed {
    logic signed [15:0] q_w;
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
  } quat_t;

  // output word: one matrix entry
  typedef struct packed {
    logic signed [15:0] entry_value;
    logic [3:0]         entry_index;
    logic               last_entry;
    logic               norm_fault;
  } entry_t;

  // register indexes
  localparam logic [1:0] REG_EPS  = 2'd0;
  localparam logic [1:0] REG_MODE = 2'd1;

  // bit steps of the square root and of each divide
  localparam int SQ_STEPS  = 17;
  localparam int DIV_STEPS = 15;

  localparam logic [3:0] LAST_INDEX = 4'd8;

  // l1 block: row/column permutation and per-row/column sign (1 = negate)
  localparam int PERM [3] = '{1, 2, 0};
  localparam logic [2:0] ROW_NEG = 3'b011;

  // 1.0 in Q.28
  localparam logic signed [32:0] ONE_Q28 = 33'sd268435456;

  // round Q.28 to Q2.14, nearest with ties away from zero, saturate to +-1.0
  function automatic logic signed [15:0] to_q14(input logic signed [32:0] v);
    logic [32:0] mag;
    logic [18:0] r;
    mag = v[32] ? 33'(-v) : 33'(v);
    r = 19'((mag + 33'd8192) >> 14);
    if (r > 19'd16384) r = 19'd16384;
    return v[32] ? -16'(r) : 16'(r);
  endfunction

endpackage

// ----- hw/rtl/quaternion_to_rotation_matrix_unit.sv -----
`timescale 1ns / 1ps

// Quaternion to 3x3 rotation matrix. Each input word is a Q4.12 quaternion;
// the block normalizes it (norm from a bit-per-stage square root, components
// from four bit-per-stage restoring dividers) and sends the nine row-major
// entries in Q2.14 as nine output words, last_entry marking the ninth. With
// output_mode set, the permuted, sign-flipped l1 block is sent instead. A zero
// norm gives nine zero entries with norm_fault set. The pipeline is 40 stages
// deep; the single output channel carries one entry per cycle while out_stall
// is low, which limits the sustained rate to one quaternion per nine entries.
// Configuration writes are always ready and take effect for quaternions
// accepted afterwards.
module quaternion_to_rotation_matrix_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  q2rm_pkg::quat_t      in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output q2rm_pkg::entry_t     out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [14:0]          cfg_data
);

  // configuration registers
  logic [14:0] eps;
  logic        output_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps         <= '0;
      output_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        q2rm_pkg::REG_EPS:  eps         <= cfg_data;
        q2rm_pkg::REG_MODE: output_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // global advance: last stage empty or handed to the serializer
  logic en;
  logic load;
  logic ser_take;
  logic ser_busy;
  logic [3:0] ser_idx;
  logic v7;

  assign ser_take = !ser_busy || (!out_stall && ser_idx == q2rm_pkg::LAST_INDEX);
  assign load     = v7 && ser_take;
  assign en       = !v7 || ser_take;
  assign in_stall = !en;

  // stage 0: capture
  logic              v0;
  logic [3:0][15:0]  c0;
  logic [14:0]       eps0;
  logic              mode0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= in_valid;
    if (en) begin
      c0    <= {in_data.q_w, in_data.q_x, in_data.q_y, in_data.q_z};
      eps0  <= eps;
      mode0 <= output_mode;
    end
  end

  // stage 1: squares
  logic              v1;
  logic [3:0][30:0]  sq1;
  logic [29:0]       esq1;
  logic [3:0][15:0]  c1;
  logic              mode1;
  logic [3:0][31:0]  sqp;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      sqp[l] = 32'($signed(c0[l])) * 32'($signed(c0[l]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
    if (en) begin
      for (int l = 0; l < 4; l++) sq1[l] <= sqp[l][30:0];
      esq1  <= 30'(eps0) * 30'(eps0);
      c1    <= c0;
      mode1 <= mode0;
    end
  end

  // square root pipeline, stage 2 loads index 0
  logic [33:0]       sq_rem  [0:q2rm_pkg::SQ_STEPS];
  logic [16:0]       sq_root [0:q2rm_pkg::SQ_STEPS];
  logic [3:0][15:0]  sq_c    [0:q2rm_pkg::SQ_STEPS];
  logic              sq_mode [0:q2rm_pkg::SQ_STEPS];
  logic              sq_v    [0:q2rm_pkg::SQ_STEPS];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (en) sq_v[0] <= v1;
    if (en) begin
      sq_rem[0]  <= 34'(sq1[0]) + 34'(sq1[1]) + 34'(sq1[2]) + 34'(sq1[3]) + 34'(esq1);
      sq_root[0] <= '0;
      sq_c[0]    <= c1;
      sq_mode[0] <= mode1;
    end
  end

  for (genvar k = 0; k < q2rm_pkg::SQ_STEPS; k++) begin : g_sqrt
    localparam int B = q2rm_pkg::SQ_STEPS - 1 - k;
    logic [35:0] trial;
    logic        take;

    // candidate root bit: rem >= root*2^(B+1) + 2^(2B)
    assign trial = ({19'd0, sq_root[k]} << (B + 1)) + (36'd1 << (2 * B));
    assign take  = {2'b00, sq_rem[k]} >= trial;

    always_ff @(posedge clk) begin
      if (rst) sq_v[k+1] <= 1'b0;
      else if (en) sq_v[k+1] <= sq_v[k];
      if (en) begin
        sq_rem[k+1]  <= take ? 34'({2'b00, sq_rem[k]} - trial) : sq_rem[k];
        sq_root[k+1] <= take ? (sq_root[k] | (17'd1 << B)) : sq_root[k];
        sq_c[k+1]    <= sq_c[k];
        sq_mode[k+1] <= sq_mode[k];
      end
    end
  end

  // divide pipeline, stage 3 loads index 0: q = floor((2*mag*2^14 + n) / 2n)
  logic [3:0][31:0]  dv_rem   [0:q2rm_pkg::DIV_STEPS];
  logic [3:0][14:0]  dv_q     [0:q2rm_pkg::DIV_STEPS];
  logic [17:0]       dv_d     [0:q2rm_pkg::DIV_STEPS];
  logic [3:0]        dv_neg   [0:q2rm_pkg::DIV_STEPS];
  logic              dv_fault [0:q2rm_pkg::DIV_STEPS];
  logic              dv_mode  [0:q2rm_pkg::DIV_STEPS];
  logic              dv_v     [0:q2rm_pkg::DIV_STEPS];
  logic [16:0]       nrm;
  logic [3:0][16:0]  mag3;
  logic [3:0]        neg3;

  assign nrm = sq_root[q2rm_pkg::SQ_STEPS];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      neg3[l] = sq_c[q2rm_pkg::SQ_STEPS][l][15];
      mag3[l] = neg3[l] ? 17'(-$signed(17'($signed(sq_c[q2rm_pkg::SQ_STEPS][l]))))
                        : 17'(sq_c[q2rm_pkg::SQ_STEPS][l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (en) dv_v[0] <= sq_v[q2rm_pkg::SQ_STEPS];
    if (en) begin
      for (int l = 0; l < 4; l++) dv_rem[0][l] <= {mag3[l], 15'd0} + 32'(nrm);
      dv_q[0]     <= '0;
      dv_d[0]     <= {nrm, 1'b0};
      dv_neg[0]   <= neg3;
      dv_fault[0] <= (nrm == '0);
      dv_mode[0]  <= sq_mode[q2rm_pkg::SQ_STEPS];
    end
  end

  for (genvar k = 0; k < q2rm_pkg::DIV_STEPS; k++) begin : g_div
    localparam int J = q2rm_pkg::DIV_STEPS - 1 - k;
    logic [32:0]      sub;
    logic [3:0][31:0] nrem;
    logic [3:0][14:0] nq;

    assign sub = {15'd0, dv_d[k]} << J;

    // one quotient bit per lane
    always_comb begin
      for (int l = 0; l < 4; l++) begin
        if ({1'b0, dv_rem[k][l]} >= sub) begin
          nrem[l] = 32'({1'b0, dv_rem[k][l]} - sub);
          nq[l]   = dv_q[k][l] | (15'd1 << J);
        end else begin
          nrem[l] = dv_rem[k][l];
          nq[l]   = dv_q[k][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv_v[k+1] <= 1'b0;
      else if (en) dv_v[k+1] <= dv_v[k];
      if (en) begin
        dv_rem[k+1]   <= nrem;
        dv_q[k+1]     <= nq;
        dv_d[k+1]     <= dv_d[k];
        dv_neg[k+1]   <= dv_neg[k];
        dv_fault[k+1] <= dv_fault[k];
        dv_mode[k+1]  <= dv_mode[k];
      end
    end
  end

  // stage 4: signed normalized components w, x, y, z
  logic                v4;
  logic signed [15:0]  u4 [4];
  logic                fault4;
  logic                mode4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= dv_v[q2rm_pkg::DIV_STEPS];
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        u4[3-l] <= dv_neg[q2rm_pkg::DIV_STEPS][l]
                   ? -$signed({1'b0, dv_q[q2rm_pkg::DIV_STEPS][l]})
                   :  $signed({1'b0, dv_q[q2rm_pkg::DIV_STEPS][l]});
      end
      fault4 <= dv_fault[q2rm_pkg::DIV_STEPS];
      mode4  <= dv_mode[q2rm_pkg::DIV_STEPS];
    end
  end

  // stage 5: products xx yy zz xy xz yz wx wy wz (u4: 0=w 1=x 2=y 3=z)
  logic                v5;
  logic signed [31:0]  pr5 [9];
  logic                fault5;
  logic                mode5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
    if (en) begin
      pr5[0] <= u4[1] * u4[1];
      pr5[1] <= u4[2] * u4[2];
      pr5[2] <= u4[3] * u4[3];
      pr5[3] <= u4[1] * u4[2];
      pr5[4] <= u4[1] * u4[3];
      pr5[5] <= u4[2] * u4[3];
      pr5[6] <= u4[0] * u4[1];
      pr5[7] <= u4[0] * u4[2];
      pr5[8] <= u4[0] * u4[3];
      fault5 <= fault4;
      mode5  <= mode4;
    end
  end

  // stage 6: exact entries in Q.28
  logic                v6;
  logic signed [32:0]  sm6 [9];
  logic                fault6;
  logic                mode6;
  logic signed [32:0]  px [9];

  always_comb begin
    for (int i = 0; i < 9; i++) px[i] = 33'(pr5[i]);
  end

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
    if (en) begin
      sm6[0] <= q2rm_pkg::ONE_Q28 - ((px[1] + px[2]) <<< 1);
      sm6[1] <= (px[3] - px[8]) <<< 1;
      sm6[2] <= (px[4] + px[7]) <<< 1;
      sm6[3] <= (px[3] + px[8]) <<< 1;
      sm6[4] <= q2rm_pkg::ONE_Q28 - ((px[0] + px[2]) <<< 1);
      sm6[5] <= (px[5] - px[6]) <<< 1;
      sm6[6] <= (px[4] - px[7]) <<< 1;
      sm6[7] <= (px[5] + px[6]) <<< 1;
      sm6[8] <= q2rm_pkg::ONE_Q28 - ((px[0] + px[1]) <<< 1);
      fault6 <= fault5;
      mode6  <= mode5;
    end
  end

  // stage 7: round, saturate, zero on fault
  logic signed [15:0]  rot7 [9];
  logic                fault7;
  logic                mode7;

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
    if (en) begin
      for (int i = 0; i < 9; i++) rot7[i] <= fault6 ? '0 : q2rm_pkg::to_q14(sm6[i]);
      fault7 <= fault6;
      mode7  <= mode6;
    end
  end

  // entry selection: plain matrix, or the l1 block when mode7 is set
  logic signed [15:0] ent_load [9];

  always_comb begin
    int src;
    src = 0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        src = q2rm_pkg::PERM[r] * 3 + q2rm_pkg::PERM[k];
        if (mode7) begin
          ent_load[r*3+k] = (q2rm_pkg::ROW_NEG[r] ^ q2rm_pkg::ROW_NEG[k])
                            ? -rot7[src] : rot7[src];
        end else begin
          ent_load[r*3+k] = rot7[r*3+k];
        end
      end
    end
  end

  // output serializer: nine words per quaternion
  logic signed [15:0] ser_ent [9];
  logic               ser_fault;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_busy <= 1'b0;
      ser_idx  <= '0;
    end else if (load) begin
      ser_busy <= 1'b1;
      ser_idx  <= '0;
    end else if (ser_busy && !out_stall) begin
      if (ser_idx == q2rm_pkg::LAST_INDEX) ser_busy <= 1'b0;
      else ser_idx <= ser_idx + 4'd1;
    end
    if (load) begin
      ser_ent   <= ent_load;
      ser_fault <= fault7;
    end
  end

  assign out_valid            = ser_busy;
  assign out_data.entry_value = ser_ent[ser_idx];
  assign out_data.entry_index = ser_idx;
  assign out_data.last_entry  = (ser_idx == q2rm_pkg::LAST_INDEX);
  assign out_data.norm_fault  = ser_fault;

  // checks
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.norm_fault |-> out_data.entry_value == 16'sd0)
    else $error("faulted entry not zero");

  a_entry_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.entry_value <= 16'sd16384 && out_data.entry_value >= -16'sd16384))
    else $error("entry beyond one");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last_entry
      |=> out_valid && out_data.entry_index == $past(out_data.entry_index) + 4'd1)
    else $error("entry index skipped");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    v7 && !en |=> v7 && $stable(fault7))
    else $error("last stage lost while stalled");

endmodule

// ----- dv/tb_quaternion_to_rotation_matrix_unit.sv -----
`timescale 1ns / 1ps

module tb_quaternion_to_rotation_matrix_unit;

  // matrix predictor and scoreboard of expected entries
  class matrix_scoreboard;
    q2rm_pkg::entry_t pending[$];
    bit [14:0] eps_val;
    bit mode_l1;
    int mismatches;
    int entries_seen;
    int quats_seen;

    function automatic logic [63:0] root64(input logic [63:0] op);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > op) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (op >= res + bitv) begin
          op = op - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function automatic longint unit_comp(input longint c, input longint n);
      longint mag;
      longint q;
      mag = c < 0 ? -c : c;
      q = (2 * (mag <<< 14) + n) / (2 * n);
      return c < 0 ? -q : q;
    endfunction

    function automatic longint round_q14(input longint v);
      longint mag;
      longint r;
      mag = v < 0 ? -v : v;
      r = (mag + 8192) >>> 14;
      if (r > 16384) r = 16384;
      return v < 0 ? -r : r;
    endfunction

    // predict the nine entries of one quaternion
    function void note_quat(input q2rm_pkg::quat_t q);
      longint c[4];
      longint rot[9];
      longint ent[9];
      longint w, x, y, z, one, n;
      logic [63:0] sum;
      q2rm_pkg::entry_t e;
      bit fault;
      int sg[3];
      c[0] = q.q_w; c[1] = q.q_x; c[2] = q.q_y; c[3] = q.q_z;
      sum = 64'(eps_val) * 64'(eps_val);
      for (int i = 0; i < 4; i++) sum += 64'(c[i] * c[i]);
      n = longint'(root64(sum));
      fault = (n == 0);
      sg = '{-1, -1, 1};
      one = 64'd1 << 28;
      for (int i = 0; i < 9; i++) ent[i] = 0;
      if (!fault) begin
        w = unit_comp(c[0], n); x = unit_comp(c[1], n);
        y = unit_comp(c[2], n); z = unit_comp(c[3], n);
        rot[0] = round_q14(one - 2 * (y * y + z * z));
        rot[1] = round_q14(2 * (x * y - w * z));
        rot[2] = round_q14(2 * (x * z + w * y));
        rot[3] = round_q14(2 * (x * y + w * z));
        rot[4] = round_q14(one - 2 * (x * x + z * z));
        rot[5] = round_q14(2 * (y * z - w * x));
        rot[6] = round_q14(2 * (x * z - w * y));
        rot[7] = round_q14(2 * (y * z + w * x));
        rot[8] = round_q14(one - 2 * (x * x + y * y));
        for (int r = 0; r < 3; r++)
          for (int k = 0; k < 3; k++)
            ent[r * 3 + k] = mode_l1 ?
                rot[((r + 1) % 3) * 3 + (k + 1) % 3] * sg[r] * sg[k] : rot[r * 3 + k];
      end
      for (int i = 0; i < 9; i++) begin
        e.entry_value = 16'(ent[i]);
        e.entry_index = 4'(i);
        e.last_entry = (4'(i) == q2rm_pkg::LAST_INDEX);
        e.norm_fault = fault;
        pending.push_back(e);
      end
      quats_seen++;
    endfunction

    // compare one received entry with the oldest expectation
    function void check_entry(input q2rm_pkg::entry_t got);
      q2rm_pkg::entry_t exp_e;
      entries_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected entry %p", got);
        return;
      end
      exp_e = pending.pop_front();
      if (got !== exp_e) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"entry mismatch: exp val=%0d idx=%0d last=%0d flt=%0d,",
                    " got val=%0d idx=%0d last=%0d flt=%0d"},
                   exp_e.entry_value, exp_e.entry_index, exp_e.last_entry, exp_e.norm_fault,
                   got.entry_value, got.entry_index, got.last_entry, got.norm_fault);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  q2rm_pkg::quat_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  q2rm_pkg::entry_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = q2rm_pkg::REG_EPS;
  logic [14:0] cfg_data = '0;

  matrix_scoreboard board = new();
  int stall_mode = 0;

  quaternion_to_rotation_matrix_unit dut (.*);

  always #1 clk = ~clk;

  // received entries go to the scoreboard
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_entry(out_data);
  end

  // receiver stall pattern, changed per phase
  always @(posedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 7) < 5);
    endcase
  end

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == q2rm_pkg::REG_EPS) board.eps_val = val;
    else if (idx == q2rm_pkg::REG_MODE) board.mode_l1 = val[0];
  endtask

  // send one quaternion word, holding it until taken
  task automatic send_quat(input q2rm_pkg::quat_t q);
    in_valid <= 1'b1;
    in_data <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_quat(q);
  endtask

  task automatic idle_gap(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // wait for all expected entries, then drain the pipeline
  task automatic drain();
    idle_gap(1);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic q2rm_pkg::quat_t rand_quat();
    q2rm_pkg::quat_t q;
    int kind;
    kind = $urandom_range(0, 9);
    q = q2rm_pkg::quat_t'({$urandom, $urandom});
    // half reduced-range quaternions, some small and some raw full-range words
    if (kind < 5) begin
      q.q_w = 16'($signed(q.q_w) >>> 2); q.q_x = 16'($signed(q.q_x) >>> 2);
      q.q_y = 16'($signed(q.q_y) >>> 2); q.q_z = 16'($signed(q.q_z) >>> 2);
    end else if (kind < 7) begin
      q.q_w = 16'($signed(q.q_w) >>> 10); q.q_x = 16'($signed(q.q_x) >>> 10);
      q.q_y = 16'($signed(q.q_y) >>> 10); q.q_z = 16'($signed(q.q_z) >>> 10);
    end
    return q;
  endfunction

  task automatic random_phase(input int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 8);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_quat(rand_quat());
        left--;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 20));
    end
  endtask

  initial begin
    q2rm_pkg::quat_t q;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: identity, axes, extremes, zero norm, unknown index
    write_reg(q2rm_pkg::REG_EPS, 15'd0);
    write_reg(q2rm_pkg::REG_MODE, 1'b0);
    send_quat('{16'sd4096, 16'sd0, 16'sd0, 16'sd0});
    send_quat('{16'sd0, 16'sd4096, 16'sd0, 16'sd0});
    send_quat('{16'sd0, 16'sd0, 16'sd4096, 16'sd0});
    send_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd4096});
    send_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
    send_quat('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
    send_quat('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
    send_quat('{16'sd32767, -16'sd32768, 16'sd1, -16'sd1});
    send_quat('{16'sd1, 16'sd0, 16'sd0, 16'sd0});
    send_quat('{16'sd2896, 16'sd2896, 16'sd0, 16'sd0});
    drain();
    write_reg(2'd2, 15'h7fff);
    write_reg(2'd3, 15'h0001);
    write_reg(q2rm_pkg::REG_MODE, 1'b1);
    send_quat('{16'sd4096, 16'sd0, 16'sd0, 16'sd0});
    send_quat('{16'sd2048, -16'sd2048, 16'sd2048, -16'sd2048});
    send_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
    send_quat('{-16'sd32768, 16'sd32767, -16'sd5, 16'sd1000});
    drain();
    write_reg(q2rm_pkg::REG_EPS, 15'h7fff);
    send_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
    send_quat('{16'sd100, -16'sd100, 16'sd7, 16'sd3});
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 4; ph++) begin
      stall_mode = ph % 3;
      write_reg(q2rm_pkg::REG_EPS, (ph == 3) ? 15'd1 : 15'($urandom_range(0, 600)));
      write_reg(q2rm_pkg::REG_MODE, ph[0]);
      random_phase(25);
      drain();
    end

    $display("covered %0d quaternions and %0d entries in both modes with eps 0..max",
             board.quats_seen, board.entries_seen);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout");
    $display("tb: failure");
    $finish;
  end

endmodule
